// ===== src/rail_fence_transposition_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rail fence transposition unit assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RAIL_FENCE_TRANSPOSITION_UNIT_MACROS_SVH
`define RAIL_FENCE_TRANSPOSITION_UNIT_MACROS_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define RFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rail fence check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rail fence check failed");

`endif

// ===== src/rft_pkg.sv =====
// ----------------------------------------------------------------------------
// Rail fence transposition package
// Shared constants, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rft_pkg;

  localparam int MaxLen   = 64;
  localparam int MaxRails = 16;

  localparam int ByteW      = 8;
  localparam int RailCountW = 5;
  localparam int CfgDataW   = 5;
  localparam int CfgIdxW    = 1;

  localparam logic [RailCountW-1:0] RailCountReset   = 5'd2;
  localparam logic                  DecryptModeReset = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAIL_COUNT   = 1'b0,
    CFG_DECRYPT_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PERM,
    ST_PERM_DRAIN,
    ST_EMIT,
    ST_EMIT_WAIT
  } state_e;

  typedef struct packed {
    logic load;        // input transfer: store the byte or flag overflow
    logic restart;     // rewind the rail walker and the sequence counter
    logic advance;     // step the rail walker and the sequence counter
    logic rd_store;    // read the message store
    logic src_walk;    // message store address from the walker, else sequential
    logic rd_res;      // read the permuted store at the sequential address
    logic perm_issue;  // write the read byte into the permuted store next cycle
    logic emit_issue;  // the read in flight becomes a result
    logic msg_clr;     // empty the buffer for the next message
  } cmd_t;

  typedef struct packed {
    logic decrypt;
    logic walk_last;   // the current sequence step is the final one
    logic can_issue;   // the result pipe has room for another read
    logic last_done;   // the final result moves into the output register
  } status_t;

endpackage

// ===== src/rft_if.sv =====
// ----------------------------------------------------------------------------
// Rail fence stream interfaces
// Valid/ready channels for message bytes in and transformed bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rft_in_if;
  logic                    valid;
  logic                    ready;
  logic [rft_pkg::ByteW-1:0] data_byte;
  logic                    last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rft_out_if;
  logic                    valid;
  logic                    ready;
  logic [rft_pkg::ByteW-1:0] out_byte;
  logic                    out_last;
  logic                    truncated;

  modport source (output valid, output out_byte, output out_last, output truncated,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input truncated,
                output ready);
endinterface

// ===== src/rft_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rail fence controller
// Sequences loading, the decrypt permutation pass and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rft_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  rft_pkg::status_t status_i,
  output rft_pkg::cmd_t    cmd_o
);

  rft_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rft_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      rft_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.restart = 1'b1;
            state_d = status_i.decrypt ? rft_pkg::ST_PERM : rft_pkg::ST_EMIT;
          end
        end
      end
      rft_pkg::ST_PERM: begin
        // Byte k of the ciphertext goes to its position on the zigzag.
        cmd_o.rd_store   = 1'b1;
        cmd_o.perm_issue = 1'b1;
        cmd_o.advance    = 1'b1;
        if (status_i.walk_last) begin
          state_d = rft_pkg::ST_PERM_DRAIN;
        end
      end
      rft_pkg::ST_PERM_DRAIN: begin
        cmd_o.restart = 1'b1;
        state_d = rft_pkg::ST_EMIT;
      end
      rft_pkg::ST_EMIT: begin
        if (status_i.can_issue) begin
          cmd_o.rd_res     = status_i.decrypt;
          cmd_o.rd_store   = !status_i.decrypt;
          cmd_o.src_walk   = 1'b1;
          cmd_o.emit_issue = 1'b1;
          cmd_o.advance    = 1'b1;
          if (status_i.walk_last) begin
            state_d = rft_pkg::ST_EMIT_WAIT;
          end
        end
      end
      rft_pkg::ST_EMIT_WAIT: begin
        if (status_i.last_done) begin
          cmd_o.msg_clr = 1'b1;
          state_d = rft_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = rft_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ===== src/rft_datapath.sv =====
// ----------------------------------------------------------------------------
// Rail fence datapath
// Message store, permuted store, zigzag rail walker, configuration
// registers and the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rft_datapath #(
  parameter int MAX_LEN   = rft_pkg::MaxLen,
  parameter int MAX_RAILS = rft_pkg::MaxRails
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rft_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rft_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [rft_pkg::ByteW-1:0]      in_byte_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [rft_pkg::ByteW-1:0]      out_byte_o,
  output logic                           out_last_o,
  output logic                           out_trunc_o,
  input  rft_pkg::cmd_t                  cmd_i,
  output rft_pkg::status_t               status_o
);

  localparam int AddrW = $clog2(MAX_LEN);
  localparam int CntW  = $clog2(MAX_LEN + 1);
  localparam int RailW = $clog2(MAX_RAILS + 1);
  localparam int EffW  = (RailW > rft_pkg::RailCountW) ? RailW : rft_pkg::RailCountW;
  localparam int WalkW = $clog2(MAX_LEN + 2 * MAX_RAILS + 1);

  // Configuration registers.
  logic [rft_pkg::RailCountW-1:0] rail_count_q;
  logic                           decrypt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_count_q <= rft_pkg::RailCountReset;
      decrypt_q    <= rft_pkg::DecryptModeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rft_pkg::CFG_RAIL_COUNT:   rail_count_q <= cfg_data_i[rft_pkg::RailCountW-1:0];
        rft_pkg::CFG_DECRYPT_MODE: decrypt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Rail count as used: zero means one rail, large values saturate.
  logic [EffW-1:0]  rc_ext;
  logic [RailW-1:0] rails;
  always_comb begin
    rc_ext = EffW'(rail_count_q);
    if (rc_ext == '0) begin
      rails = RailW'(1);
    end else if (rc_ext > EffW'(MAX_RAILS)) begin
      rails = RailW'(MAX_RAILS);
    end else begin
      rails = rc_ext[RailW-1:0];
    end
  end

  // Message buffer fill state.
  logic [CntW-1:0] fill_q;
  logic            ovf_q;
  logic            full;
  assign full = (fill_q == CntW'(MAX_LEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.msg_clr) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  // Rail walker: visits positions rail by rail, each rail in increasing order.
  // Within a rail the gaps alternate between period-2r and 2r.
  logic [RailW-1:0] rail_q, rail_d;
  logic [WalkW-1:0] pos_q, pos_d;
  logic             phase_q, phase_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [WalkW-1:0] period, twice_r, step, cand;
  logic             walk_last;

  assign walk_last = ((CntW'(k_q) + CntW'(1)) == fill_q);

  always_comb begin
    period  = WalkW'({rails - RailW'(1), 1'b0});
    twice_r = WalkW'({rail_q, 1'b0});
    step    = phase_q ? twice_r : (period - twice_r);
    if (rails == RailW'(1)) begin
      step = WalkW'(1);
    end else if (step == '0) begin
      step = period;
    end
    cand = pos_q + step;

    rail_d  = rail_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    k_d     = k_q;
    if (cmd_i.restart) begin
      rail_d  = '0;
      pos_d   = '0;
      phase_d = 1'b0;
      k_d     = '0;
    end else if (cmd_i.advance) begin
      k_d = k_q + AddrW'(1);
      if (cand < WalkW'(fill_q)) begin
        pos_d   = cand;
        phase_d = !phase_q;
      end else begin
        rail_d  = rail_q + RailW'(1);
        pos_d   = WalkW'(rail_q) + WalkW'(1);
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q  <= '0;
      pos_q   <= '0;
      phase_q <= 1'b0;
      k_q     <= '0;
    end else begin
      rail_q  <= rail_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  // Message store and permuted store, both with registered read data.
  logic [rft_pkg::ByteW-1:0] store_mem [MAX_LEN];
  logic [rft_pkg::ByteW-1:0] res_mem   [MAX_LEN];
  logic [rft_pkg::ByteW-1:0] store_rdata_q, res_rdata_q;
  logic [AddrW-1:0]          store_raddr;
  logic                      perm_wr_q;
  logic [AddrW-1:0]          perm_addr_q;

  assign store_raddr = cmd_i.src_walk ? pos_q[AddrW-1:0] : k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      store_mem[fill_q[AddrW-1:0]] <= in_byte_i;
    end
    if (cmd_i.rd_store) begin
      store_rdata_q <= store_mem[store_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (perm_wr_q) begin
      res_mem[perm_addr_q] <= store_rdata_q;
    end
    if (cmd_i.rd_res) begin
      res_rdata_q <= res_mem[k_q];
    end
    perm_addr_q <= pos_q[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_wr_q <= 1'b0;
    end else begin
      perm_wr_q <= cmd_i.perm_issue;
    end
  end

  // Result pipe: one read in flight, then the output register.
  logic pend_q, pend_last_q;
  logic out_valid_q;
  logic capture;

  assign capture = pend_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_issue) begin
        pend_q      <= 1'b1;
        pend_last_q <= walk_last;
      end else if (capture) begin
        pend_q <= 1'b0;
      end
      if (capture) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_byte_o  <= decrypt_q ? res_rdata_q : store_rdata_q;
      out_last_o  <= pend_last_q;
      out_trunc_o <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.decrypt   = decrypt_q;
  assign status_o.walk_last = walk_last;
  assign status_o.can_issue = !pend_q || capture;
  assign status_o.last_done = capture && pend_last_q;

endmodule

// ===== src/rail_fence_transposition_unit.sv =====
// ----------------------------------------------------------------------------
// Rail fence transposition unit
// Buffers a message and emits it in rail fence (zigzag) order or undoes it.
// ----------------------------------------------------------------------------
// Message bytes arrive on in_if, one transfer per byte; last_byte closes the
// message. Up to MAX_LEN bytes are kept, later ones are dropped and every
// result of that message then carries truncated. The user must write
// rail_count and decrypt_mode on the cfg port only between messages; the
// block does not enforce it. The input stays ready while a message loads.
// After the closing transfer the input stalls while the message is emitted
// on out_if: encryption reads the message store in rail order, one byte per
// cycle, and the first result passes the store's read register and then the
// output register. Decryption first scatters the n bytes into a second
// store, then reads it out in order at one byte per cycle. The single read
// port of each store sets the pace. When the receiver holds ready low, the
// output register and one read in flight hold their bytes and emission
// pauses. The input reopens once the final result sits in the output
// register. Reset empties the buffer and sets two rails and encryption; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rail_fence_transposition_unit #(
  parameter int MAX_LEN   = rft_pkg::MaxLen,
  parameter int MAX_RAILS = rft_pkg::MaxRails
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rft_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rft_pkg::CfgDataW-1:0] cfg_data_i,
  rft_in_if.sink                       in_if,
  rft_out_if.source                    out_if
);

  rft_pkg::cmd_t    cmd;
  rft_pkg::status_t status;

  rft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.last_byte),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rft_datapath #(
    .MAX_LEN   (MAX_LEN),
    .MAX_RAILS (MAX_RAILS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (in_if.data_byte),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_byte_o  (out_if.out_byte),
    .out_last_o  (out_if.out_last),
    .out_trunc_o (out_if.truncated),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== src/rft_checker.sv =====
// ----------------------------------------------------------------------------
// Rail fence port checker
// Port-level properties of the transposition unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rail_fence_transposition_unit_macros.svh"

module rft_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rft_pkg::ByteW-1:0] out_byte_i,
  input logic                      out_last_i,
  input logic                      out_trunc_i
);

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // A closing transfer always starts an emission, which blocks the input.
  `RFT_ASSERT_NEXT(a_close_stalls_input, clk_i, rst_ni, in_xfer && in_last_i, !in_ready_i)

  // A stalled result keeps its byte and last flag.
  `RFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_byte_i) && $stable(out_last_i))

  // The truncation flag is the same on every result of one message.
  `RFT_ASSERT_NEXT(a_trunc_per_msg, clk_i, rst_ni, out_xfer && !out_last_i,
                   !out_valid_i || (out_trunc_i == $past(out_trunc_i)))

  // Results of a message never interleave with loading of the next one.
  `RFT_ASSERT_NOW(a_no_load_mid_msg, clk_i, rst_ni,
                  out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind rail_fence_transposition_unit rft_checker u_rft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_last_i   (in_if.last_byte),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_byte_i  (out_if.out_byte),
  .out_last_i  (out_if.out_last),
  .out_trunc_i (out_if.truncated)
);
